### rtl/dpcr_pkg.sv
// shared types, constants and arithmetic helpers of the disc pair collision resolver
package dpcr_pkg;

    localparam int NB        = 30;
    localparam int SQ_STEPS  = 33;
    localparam int DIV_STEPS = 31;
    localparam int WIDE_W    = 72;
    localparam logic [30:0] Q_ONE = 31'(64'd1 << NB);

    typedef struct packed {
        logic signed [31:0] first_pos_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_vel_y;
        logic        [30:0] first_mass;
        logic        [30:0] first_diameter;
        logic signed [31:0] second_pos_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_vel_y;
        logic        [30:0] second_mass;
        logic        [30:0] second_diameter;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic               degenerate;
        logic signed [31:0] new_first_pos_x;
        logic signed [31:0] new_first_pos_y;
        logic signed [31:0] new_first_vel_x;
        logic signed [31:0] new_first_vel_y;
        logic signed [31:0] new_second_pos_x;
        logic signed [31:0] new_second_pos_y;
        logic signed [31:0] new_second_vel_x;
        logic signed [31:0] new_second_vel_y;
    } t_out;

    typedef logic signed [WIDE_W-1:0] t_wide;

    // round half away from zero after a right shift
    function automatic t_wide rnd_sh(input t_wide p, input int unsigned sh);
        t_wide m;
        t_wide r;
        m = p[WIDE_W-1] ? -p : p;
        r = (m + (t_wide'(1) << (sh - 1))) >> sh;
        return p[WIDE_W-1] ? -r : r;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

### rtl/disc_pair_collision_resolver_core.sv
// disc pair collision resolver: pipelined contact test, elastic response and separation
//
// One disc pair is taken in every clock cycle (busy never rises) and its result word
// appears on o_result with o_done once it has passed the whole pipeline: the square
// root of the squared centre distance (33 stages, one root bit each, with the mass
// ratio divider running alongside), then the two normal vector dividers (31 stages,
// one quotient bit each) and seven multiply and round stages.
// Results are not held: the receiver must take each word in the cycle o_done is high.
module disc_pair_collision_resolver_core
    import dpcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_in  i_item,
    output logic o_done,
    output t_out o_result
);

    localparam int LAT = 3 + SQ_STEPS + 1 + DIV_STEPS + 1 + 7;

    typedef struct packed {
        t_in  item;
        logic hit;
        logic degen;
        logic app;
    } t_side;

    typedef struct packed {
        t_in                item;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [31:0] s;
        logic        [31:0] tm;
    } t_sa;

    typedef struct packed {
        t_in                item;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [31:0] s;
        logic        [31:0] tm;
        logic        [63:0] sqx;
        logic        [63:0] sqy;
        logic        [63:0] ss;
    } t_sb;

    typedef struct packed {
        t_in                item;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [31:0] s;
        logic        [31:0] tm;
        logic               hit;
        logic               degen;
        logic        [36:0] sq_rem;
        logic        [32:0] sq_root;
        logic        [65:0] sq_rad;
        logic        [63:0] md_rem;
        logic        [30:0] md_q;
    } t_sq;

    typedef struct packed {
        t_side              sd;
        logic        [32:0] cdist;
        logic signed [34:0] ov2;
        logic        [30:0] q1;
        logic        [30:0] q2;
        logic        [31:0] r1;
        logic        [31:0] r2;
        logic               sx;
        logic               sy;
        logic        [63:0] nrx;
        logic        [63:0] nry;
        logic        [30:0] qx;
        logic        [30:0] qy;
    } t_dv;

    typedef struct packed {
        t_side              sd;
        logic signed [34:0] ov2;
        logic        [30:0] q1;
        logic        [30:0] q2;
        logic        [31:0] r1;
        logic        [31:0] r2;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
    } t_nv;

    // stage registers
    logic r_a_v, r_b_v, r_n_v;
    logic r_t1_v, r_t2_v, r_t3_v, r_t4_v, r_t5_v, r_t6_v, r_t7_v;
    logic r_sq_v [0:SQ_STEPS];
    logic r_dv_v [0:DIV_STEPS];
    t_sa  r_a, n_a;
    t_sb  r_b, n_b;
    t_sq  r_sq [0:SQ_STEPS];
    t_sq  n_sq0;
    t_dv  r_dv [0:DIV_STEPS];
    t_dv  n_dv0;
    t_nv  r_n, n_n;

    t_nv                r_t1_c, r_t2_c, r_t3_c, r_t4_c;
    logic signed [63:0] r_t1_p1x, r_t1_p1y, r_t1_p2x, r_t1_p2y;
    logic signed [34:0] r_t2_v1n, r_t2_v2n, n_t2_v1n, n_t2_v2n;
    logic signed [35:0] r_t3_w;
    logic signed [68:0] r_t4_pw1, r_t4_pw2;
    logic signed [66:0] r_t4_po1, r_t4_po2;
    t_side              r_t5_sd, r_t6_sd;
    logic signed [31:0] r_t5_nx, r_t5_ny;
    logic signed [35:0] r_t5_j1, r_t5_j2, r_t5_mv1, r_t5_mv2;
    logic signed [35:0] n_t5_j1, n_t5_j2, n_t5_mv1, n_t5_mv2;
    logic signed [67:0] r_t6_a1x, r_t6_a1y, r_t6_a2x, r_t6_a2y;
    logic signed [67:0] r_t6_b1x, r_t6_b1y, r_t6_b2x, r_t6_b2y;
    t_out               r_t7, n_t7;

    assign busy = 1'b0;

    // stage a: differences and sums
    always_comb begin
        n_a.item = i_item;
        n_a.dx   = {i_item.first_pos_x[31], i_item.first_pos_x}
                 - {i_item.second_pos_x[31], i_item.second_pos_x};
        n_a.dy   = {i_item.first_pos_y[31], i_item.first_pos_y}
                 - {i_item.second_pos_y[31], i_item.second_pos_y};
        n_a.s    = {1'b0, i_item.first_diameter} + {1'b0, i_item.second_diameter};
        n_a.tm   = {1'b0, i_item.first_mass} + {1'b0, i_item.second_mass};
    end

    // stage b: squares
    always_comb begin
        logic [32:0] adx;
        logic [32:0] ady;
        adx = r_a.dx[32] ? 33'(-r_a.dx) : 33'(r_a.dx);
        ady = r_a.dy[32] ? 33'(-r_a.dy) : 33'(r_a.dy);
        n_b.item = r_a.item;
        n_b.dx   = r_a.dx;
        n_b.dy   = r_a.dy;
        n_b.s    = r_a.s;
        n_b.tm   = r_a.tm;
        n_b.sqx  = adx[31:0] * adx[31:0];
        n_b.sqy  = ady[31:0] * ady[31:0];
        n_b.ss   = r_a.s * r_a.s;
    end

    // stage c: contact test, root and mass divider setup
    always_comb begin
        logic [65:0] sumsq;
        sumsq = 66'(r_b.sqx) + 66'(r_b.sqy);
        n_sq0.item    = r_b.item;
        n_sq0.dx      = r_b.dx;
        n_sq0.dy      = r_b.dy;
        n_sq0.s       = r_b.s;
        n_sq0.tm      = r_b.tm;
        n_sq0.hit     = {sumsq, 2'b00} <= {4'b0000, r_b.ss};
        n_sq0.degen   = sumsq == 66'd0;
        n_sq0.sq_rem  = '0;
        n_sq0.sq_root = '0;
        n_sq0.sq_rad  = sumsq;
        n_sq0.md_rem  = 64'(r_b.item.first_mass) << NB;
        n_sq0.md_q    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v     <= 1'b0;
            r_b_v     <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else begin
            r_a_v     <= start && !busy;
            r_b_v     <= r_a_v;
            r_sq_v[0] <= r_b_v;
        end
        r_a     <= n_a;
        r_b     <= n_b;
        r_sq[0] <= n_sq0;
    end

    // root stages, one bit each; mass ratio divider in the first ones
    for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sq
        localparam int K = i - 1;
        t_sq n_st;
        always_comb begin
            logic [36:0] rs;
            logic [36:0] trial;
            logic [63:0] dsh;
            n_st  = r_sq[i-1];
            rs    = {r_sq[i-1].sq_rem[34:0], r_sq[i-1].sq_rad[65:64]};
            trial = {2'b00, r_sq[i-1].sq_root, 2'b01};
            n_st.sq_rad = {r_sq[i-1].sq_rad[63:0], 2'b00};
            if (rs >= trial) begin
                n_st.sq_rem  = rs - trial;
                n_st.sq_root = {r_sq[i-1].sq_root[31:0], 1'b1};
            end else begin
                n_st.sq_rem  = rs;
                n_st.sq_root = {r_sq[i-1].sq_root[31:0], 1'b0};
            end
            dsh = 64'(r_sq[i-1].tm) << ((K < DIV_STEPS) ? (DIV_STEPS - 1 - K) : 0);
            if (K < DIV_STEPS && r_sq[i-1].md_rem >= dsh) begin
                n_st.md_rem = r_sq[i-1].md_rem - dsh;
                n_st.md_q[(K < DIV_STEPS) ? (DIV_STEPS - 1 - K) : 0] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[i] <= 1'b0;
            end else begin
                r_sq_v[i] <= r_sq_v[i-1];
            end
            r_sq[i] <= n_st;
        end
    end

    // stage d: mass ratios, overlap and normal divider setup
    always_comb begin
        logic [31:0] rem1;
        logic [31:0] rem2;
        logic [32:0] adx;
        logic [32:0] ady;
        t_sq         l;
        l    = r_sq[SQ_STEPS];
        rem2 = l.md_rem[31:0];
        rem1 = (rem2 == 32'd0) ? 32'd0 : l.tm - rem2;
        adx  = l.dx[32] ? 33'(-l.dx) : 33'(l.dx);
        ady  = l.dy[32] ? 33'(-l.dy) : 33'(l.dy);
        n_dv0.sd.item  = l.item;
        n_dv0.sd.hit   = l.hit;
        n_dv0.sd.degen = l.degen;
        n_dv0.sd.app   = l.hit && !l.degen && (l.tm != 32'd0);
        n_dv0.cdist    = l.sq_root;
        n_dv0.ov2      = $signed({3'b000, l.s}) - $signed({1'b0, l.sq_root, 1'b0});
        n_dv0.q2       = l.md_q;
        n_dv0.q1       = Q_ONE - l.md_q - 31'(rem2 != 32'd0);
        n_dv0.r1       = {l.md_q, 1'b0} + 32'({rem2, 1'b0} >= {1'b0, l.tm});
        n_dv0.r2       = {n_dv0.q1, 1'b0} + 32'({rem1, 1'b0} >= {1'b0, l.tm});
        n_dv0.sx       = l.dx[32];
        n_dv0.sy       = l.dy[32];
        n_dv0.nrx      = 64'(adx) << NB;
        n_dv0.nry      = 64'(ady) << NB;
        n_dv0.qx       = '0;
        n_dv0.qy       = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else begin
            r_dv_v[0] <= r_sq_v[SQ_STEPS];
        end
        r_dv[0] <= n_dv0;
    end

    // normal vector divider stages, one quotient bit each
    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_dv
        localparam int B = DIV_STEPS - j;
        t_dv n_st;
        always_comb begin
            logic [63:0] dsh;
            n_st = r_dv[j-1];
            dsh  = 64'(r_dv[j-1].cdist) << B;
            if (r_dv[j-1].nrx >= dsh) begin
                n_st.nrx   = r_dv[j-1].nrx - dsh;
                n_st.qx[B] = 1'b1;
            end
            if (r_dv[j-1].nry >= dsh) begin
                n_st.nry   = r_dv[j-1].nry - dsh;
                n_st.qy[B] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
            r_dv[j] <= n_st;
        end
    end

    // stage n: signed normal
    always_comb begin
        t_dv l;
        l = r_dv[DIV_STEPS];
        n_n.sd  = l.sd;
        n_n.ov2 = l.ov2;
        n_n.q1  = l.q1;
        n_n.q2  = l.q2;
        n_n.r1  = l.r1;
        n_n.r2  = l.r2;
        n_n.nx  = l.sx ? -$signed({1'b0, l.qx}) : $signed({1'b0, l.qx});
        n_n.ny  = l.sy ? -$signed({1'b0, l.qy}) : $signed({1'b0, l.qy});
    end

    // normal components of the velocities
    always_comb begin
        t_wide a;
        t_wide b;
        a = rnd_sh(t_wide'(r_t1_p1x) + t_wide'(r_t1_p1y), NB);
        b = rnd_sh(t_wide'(r_t1_p2x) + t_wide'(r_t1_p2y), NB);
        n_t2_v1n = a[34:0];
        n_t2_v2n = b[34:0];
    end

    // impulses and separation moves
    always_comb begin
        t_wide a;
        t_wide b;
        t_wide c;
        t_wide d;
        a = rnd_sh(t_wide'(r_t4_pw2), NB);
        b = rnd_sh(t_wide'(r_t4_pw1), NB);
        c = rnd_sh(t_wide'(r_t4_po1), NB + 1);
        d = rnd_sh(t_wide'(r_t4_po2), NB + 1);
        n_t5_j1  = a[35:0];
        n_t5_j2  = b[35:0];
        n_t5_mv1 = c[35:0];
        n_t5_mv2 = d[35:0];
    end

    // final update, saturation and select
    always_comb begin
        t_wide dv1x, dv1y, dv2x, dv2y, dp1x, dp1y, dp2x, dp2y;
        t_in   it;
        it   = r_t6_sd.item;
        dv1x = rnd_sh(t_wide'(r_t6_a1x), NB);
        dv1y = rnd_sh(t_wide'(r_t6_a1y), NB);
        dv2x = rnd_sh(t_wide'(r_t6_a2x), NB);
        dv2y = rnd_sh(t_wide'(r_t6_a2y), NB);
        dp1x = rnd_sh(t_wide'(r_t6_b1x), NB);
        dp1y = rnd_sh(t_wide'(r_t6_b1y), NB);
        dp2x = rnd_sh(t_wide'(r_t6_b2x), NB);
        dp2y = rnd_sh(t_wide'(r_t6_b2y), NB);
        n_t7.hit        = r_t6_sd.hit;
        n_t7.degenerate = r_t6_sd.degen;
        if (r_t6_sd.app) begin
            n_t7.new_first_pos_x  = sat32(40'(it.first_pos_x) + $signed(dp1x[39:0]));
            n_t7.new_first_pos_y  = sat32(40'(it.first_pos_y) + $signed(dp1y[39:0]));
            n_t7.new_first_vel_x  = sat32(40'(it.first_vel_x) + $signed(dv1x[39:0]));
            n_t7.new_first_vel_y  = sat32(40'(it.first_vel_y) + $signed(dv1y[39:0]));
            n_t7.new_second_pos_x = sat32(40'(it.second_pos_x) - $signed(dp2x[39:0]));
            n_t7.new_second_pos_y = sat32(40'(it.second_pos_y) - $signed(dp2y[39:0]));
            n_t7.new_second_vel_x = sat32(40'(it.second_vel_x) - $signed(dv2x[39:0]));
            n_t7.new_second_vel_y = sat32(40'(it.second_vel_y) - $signed(dv2y[39:0]));
        end else begin
            n_t7.new_first_pos_x  = it.first_pos_x;
            n_t7.new_first_pos_y  = it.first_pos_y;
            n_t7.new_first_vel_x  = it.first_vel_x;
            n_t7.new_first_vel_y  = it.first_vel_y;
            n_t7.new_second_pos_x = it.second_pos_x;
            n_t7.new_second_pos_y = it.second_pos_y;
            n_t7.new_second_vel_x = it.second_vel_x;
            n_t7.new_second_vel_y = it.second_vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v  <= 1'b0;
            r_t1_v <= 1'b0;
            r_t2_v <= 1'b0;
            r_t3_v <= 1'b0;
            r_t4_v <= 1'b0;
            r_t5_v <= 1'b0;
            r_t6_v <= 1'b0;
            r_t7_v <= 1'b0;
        end else begin
            r_n_v  <= r_dv_v[DIV_STEPS];
            r_t1_v <= r_n_v;
            r_t2_v <= r_t1_v;
            r_t3_v <= r_t2_v;
            r_t4_v <= r_t3_v;
            r_t5_v <= r_t4_v;
            r_t6_v <= r_t5_v;
            r_t7_v <= r_t6_v;
        end
        r_n      <= n_n;
        r_t1_c   <= r_n;
        r_t1_p1x <= r_n.sd.item.first_vel_x * r_n.nx;
        r_t1_p1y <= r_n.sd.item.first_vel_y * r_n.ny;
        r_t1_p2x <= r_n.sd.item.second_vel_x * r_n.nx;
        r_t1_p2y <= r_n.sd.item.second_vel_y * r_n.ny;
        r_t2_c   <= r_t1_c;
        r_t2_v1n <= n_t2_v1n;
        r_t2_v2n <= n_t2_v2n;
        r_t3_c   <= r_t2_c;
        r_t3_w   <= 36'(r_t2_v2n) - 36'(r_t2_v1n);
        r_t4_c   <= r_t3_c;
        r_t4_pw1 <= r_t3_w * $signed({1'b0, r_t3_c.r1});
        r_t4_pw2 <= r_t3_w * $signed({1'b0, r_t3_c.r2});
        r_t4_po1 <= r_t3_c.ov2 * $signed({1'b0, r_t3_c.q1});
        r_t4_po2 <= r_t3_c.ov2 * $signed({1'b0, r_t3_c.q2});
        r_t5_sd  <= r_t4_c.sd;
        r_t5_nx  <= r_t4_c.nx;
        r_t5_ny  <= r_t4_c.ny;
        r_t5_j1  <= n_t5_j1;
        r_t5_j2  <= n_t5_j2;
        r_t5_mv1 <= n_t5_mv1;
        r_t5_mv2 <= n_t5_mv2;
        r_t6_sd  <= r_t5_sd;
        r_t6_a1x <= r_t5_j1 * r_t5_nx;
        r_t6_a1y <= r_t5_j1 * r_t5_ny;
        r_t6_a2x <= r_t5_j2 * r_t5_nx;
        r_t6_a2y <= r_t5_j2 * r_t5_ny;
        r_t6_b1x <= r_t5_mv1 * r_t5_nx;
        r_t6_b1y <= r_t5_mv1 * r_t5_ny;
        r_t6_b2x <= r_t5_mv2 * r_t5_nx;
        r_t6_b2y <= r_t5_mv2 * r_t5_ny;
        r_t7     <= n_t7;
    end

    assign o_done   = r_t7_v;
    assign o_result = r_t7;

    a_deg_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!o_result.degenerate || o_result.hit))
        else $error("degenerate word without hit");

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("accepted word did not come out");

    a_lat_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result word without accepted word");

    a_deg_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.degenerate) |->
            (o_result.new_first_pos_x == $past(i_item.first_pos_x, LAT)) &&
            (o_result.new_second_vel_y == $past(i_item.second_vel_y, LAT)))
        else $error("degenerate pair not passed through");

endmodule
